[rtl/tcpa_pkg.sv]
// Package for the tapered covariance pair accumulator.
// Types, commands, status codes, control states and the exp table. No dependencies.
package tcpa_pkg;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_IDX = 2'd1,
    ST_SAT = 2'd2,
    ST_RSV = 2'd3
  } status_e;

  // top-level control states
  typedef enum logic [2:0] {
    S_INIT, S_CLR, S_IDLE, S_EXP, S_RD, S_WB, S_OUT
  } state_e;

  localparam int unsigned CfgNPlots = 0;
  localparam int unsigned CfgDecay  = 1;

  localparam logic [30:0] Log2eQ30 = 31'd1549082005;
  localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;

  // 2^(-k/16) in Q1.30
  function automatic logic [30:0] pow2_tab(input logic [4:0] k);
    logic [30:0] v;
    begin
      case (k)
        5'd0:  v = 31'd1073741824;
        5'd1:  v = 31'd1028218693;
        5'd2:  v = 31'd984625594;
        5'd3:  v = 31'd942880699;
        5'd4:  v = 31'd902905651;
        5'd5:  v = 31'd864625413;
        5'd6:  v = 31'd827968132;
        5'd7:  v = 31'd792864999;
        5'd8:  v = 31'd759250125;
        5'd9:  v = 31'd727060413;
        5'd10: v = 31'd696235435;
        5'd11: v = 31'd666717336;
        5'd12: v = 31'd638450709;
        5'd13: v = 31'd611382493;
        5'd14: v = 31'd585461879;
        5'd15: v = 31'd560640218;
        5'd16: v = 31'd536870912;
        default: v = 31'd0;
      endcase
      return v;
    end
  endfunction

endpackage

[rtl/tcpa_exp.sv]
// Multi-cycle exp(-x) and contribution unit.
// Depends on tcpa_pkg.
module tcpa_exp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         rate_i,
  input  logic [31:0]         dist_i,
  input  logic signed [31:0]  weight_i,
  output logic                done_o,
  output logic signed [47:0]  contrib_o
);
  import tcpa_pkg::*;

  // Sequencer steps: x lo/hi partial products, y, interpolate, contribution.
  logic [3:0]  step_q, step_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] x_q, x_d;
  logic [39:0] y_q, y_d;
  logic [30:0] e_q, e_d;
  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [31:0] w_q, w_d;
  logic signed [47:0] c_q, c_d;

  logic [30:0] hi_v, lo_v;
  logic [51:0] ip;
  logic [5:0]  n_v;
  logic [63:0] m_v;
  logic [41:0] r_v;
  logic [60:0] yprod;

  always_comb begin
    step_d = step_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    e_d    = e_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    w_d    = w_q;
    c_d    = c_q;
    hi_v   = pow2_tab({1'b0, y_q[23:20]});
    lo_v   = pow2_tab({1'b0, y_q[23:20]} + 5'd1);
    ip     = 52'(hi_v - lo_v) * 52'(y_q[19:0]);
    n_v    = y_q[29:24] ;
    m_v    = 64'(mag_q) * 64'(e_q);
    r_v    = 42'((m_v + 64'd2097152) >> 22);
    yprod  = 61'(x_q[37:8]) * 61'(Log2eQ30);
    case (step_q)
      4'd0: begin
        if (start_i) begin
          x_d   = 64'(rate_i[15:0]) * 64'(dist_i);
          acc_d = 64'(rate_i[31:16]) * 64'(dist_i);
          neg_d = weight_i[31];
          w_d   = weight_i;
          step_d = 4'd1;
        end
      end
      4'd1: begin
        x_d = x_q + (acc_q << 16);
        mag_d = neg_q ? (32'd0 - w_q) : w_q;
        step_d = 4'd2;
      end
      4'd2: begin
        // x<2^38 here when not overflowing; x>>8 fits 30 bits
        y_d = 40'(yprod >> 30);
        step_d = 4'd3;
      end
      4'd3: begin
        e_d = hi_v - 31'(ip >> 20);
        if (x_q[63:38] != '0) e_d = '0;
        else if (y_q[39:24] > 16'd40) e_d = '0;
        else e_d = (hi_v - 31'(ip >> 20)) >> n_v;
        step_d = 4'd4;
      end
      4'd4: begin
        c_d = neg_q ? -$signed({6'd0, r_v}) : $signed({6'd0, r_v});
        step_d = 4'd5;
      end
      default: step_d = 4'd0;
    endcase
  end

  assign done_o    = (step_q == 4'd5);
  assign contrib_o = c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= 4'd0;
    else step_q <= step_d;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; x_q <= x_d; y_q <= y_d; e_q <= e_d;
    mag_q <= mag_d; neg_q <= neg_d; w_q <= w_d; c_q <= c_d;
  end
endmodule

[rtl/tapered_covariance_pair_accumulator.sv]
// Top level of the tapered covariance pair accumulator.
// Depends on tcpa_pkg and tcpa_exp.
//
// Use: items arrive on the s_axis group, one result leaves on m_axis per
// item. s_axis_tdata: command, row_plot, col_plot, distance, taper_weight.
// m_axis_tdata: status, read_value. Configuration writes (index 0 n_plots,
// 1 decay_rate) go on cfg_* while idle.
// From input transaction to m_axis_tvalid: a read passes S_EXP, S_RD
// and S_OUT; a bad index or unused command S_EXP and S_OUT; an
// accumulate the five exp unit steps, then the store read-modify-write
// and the result stage. A clear sweeps the store one entry a cycle over
// all MAX_PLOTS*(MAX_PLOTS+1)/2 entries, then goes to the result stage.
// One item is in work at a time; s_axis_tready rises in the cycle the
// result is offered. Reset: a sweep over all MAX_PLOTS*(MAX_PLOTS+1)/2
// entries (2080 by default) zeroes them, with s_axis_tready low meanwhile.
// Stall: the result waits in an output register; meanwhile the next item
// is taken and runs, store write included, up to its result stage, where
// it waits until the held result has gone.
module tapered_covariance_pair_accumulator #(
  parameter int unsigned MAX_PLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [8:2] row_plot, [15:9] col_plot, [47:16] distance,
  // [79:48] taper_weight
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [49:2] read_value
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tcpa_pkg::*;

  localparam int unsigned Depth = MAX_PLOTS * (MAX_PLOTS + 1) / 2;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW = $clog2(MAX_PLOTS + 1);

  state_e state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic        ptr_last;
  logic [6:0]  nplots_q;
  logic [31:0] decay_q;
  cmd_e        cmd_q;
  logic [AW-1:0] addr_q;
  logic        bad_q;
  logic [31:0] dist_q;
  logic signed [31:0] w_q;
  // result of the item in work, moved to the output register in S_OUT
  status_e     res_st_q, res_st_d;
  logic signed [47:0] res_val_q, res_val_d;
  logic [1:0]  ost_q, ost_d;
  logic signed [47:0] oval_q, oval_d;
  logic        ovld_q, ovld_d;

  logic signed [47:0] mem [Depth];
  logic signed [47:0] rdata_q;
  logic        mwe;
  logic [AW-1:0] maddr;
  logic signed [47:0] mwdata;

  logic        ex_start, ex_done;
  logic signed [47:0] contrib;
  logic signed [48:0] sum;
  logic        in_fire, out_fire, cfg_fire;

  // index decode
  logic [6:0] row, col, hi, lo, lim;
  logic       bad;
  logic [AW+PW:0] tri_v;
  always_comb begin
    row = s_axis_tdata[8:2];
    col = s_axis_tdata[15:9];
    lim = (32'(nplots_q) < MAX_PLOTS) ? nplots_q : 7'(MAX_PLOTS);
    bad = (row == 7'd0) || (row > lim) || (col == 7'd0) || (col > lim);
    hi  = (row > col) ? row - 7'd1 : col - 7'd1;
    lo  = (row > col) ? col - 7'd1 : row - 7'd1;
    tri_v = (AW+PW+1)'((14'(hi) * 14'(hi + 7'd1)) >> 1) + (AW+PW+1)'(lo);
  end

  tcpa_exp u_exp (
    .clk_i, .rst_ni, .start_i(ex_start), .rate_i(decay_q), .dist_i(dist_q),
    .weight_i(w_q), .done_o(ex_done), .contrib_o(contrib)
  );

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign ptr_last = (32'(ptr_q) == Depth - 1);

  always_comb begin
    sum = 49'(rdata_q) + 49'(contrib);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (ptr_last) state_d = S_IDLE;
      end
      S_CLR: begin
        if (ptr_last) state_d = S_OUT;
      end
      S_IDLE: begin
        if (in_fire) state_d = S_EXP;
      end
      S_EXP: begin
        if (cmd_q == CMD_CLEAR) state_d = S_CLR;
        else if (bad_q) state_d = S_OUT;
        else if (cmd_q inside {CMD_ACC, CMD_READ}) state_d = S_RD;
        else state_d = S_OUT;
      end
      S_RD: begin
        if (cmd_q == CMD_READ) state_d = S_OUT;
        else if (ex_done) state_d = S_WB;
      end
      S_WB: state_d = S_OUT;
      S_OUT: begin
        if (!ovld_q || out_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, store port and result registers
  always_comb begin
    ptr_d = ptr_q;
    res_st_d = res_st_q; res_val_d = res_val_q;
    ost_d = ost_q; oval_d = oval_q; ovld_d = ovld_q && !out_fire;
    mwe = 1'b0; maddr = addr_q; mwdata = '0;
    ex_start = 1'b0;
    case (state_q)
      S_INIT, S_CLR: begin
        // sweep: one zero write a cycle, pointer back to zero at the end
        mwe = 1'b1; maddr = ptr_q;
        ptr_d = ptr_last ? '0 : ptr_q + AW'(1);
        res_st_d = ST_OK; res_val_d = '0;
      end
      S_EXP: begin
        res_st_d = ST_OK; res_val_d = '0;
        if (bad_q && (cmd_q inside {CMD_ACC, CMD_READ})) res_st_d = ST_IDX;
        else if (cmd_q == CMD_ACC) ex_start = 1'b1;
      end
      S_RD: begin
        if (cmd_q == CMD_READ) res_val_d = rdata_q;
      end
      S_WB: begin
        mwe = 1'b1;
        if (sum > 49'(SumMax)) begin
          mwdata = SumMax; res_st_d = ST_SAT;
        end else if (sum < 49'(SumMin)) begin
          mwdata = SumMin; res_st_d = ST_SAT;
        end else mwdata = 48'(sum);
      end
      S_OUT: begin
        if (!ovld_q || out_fire) begin
          ost_d = res_st_q; oval_d = res_val_q; ovld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {6'd0, oval_q, ost_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; ptr_q <= '0; ovld_q <= 1'b0;
      nplots_q <= 7'd64; decay_q <= 32'd65536;
      res_st_q <= ST_OK; res_val_q <= '0;
      ost_q <= ST_OK; oval_q <= '0;
    end else begin
      state_q <= state_d; ptr_q <= ptr_d; ovld_q <= ovld_d;
      res_st_q <= res_st_d; res_val_q <= res_val_d;
      ost_q <= ost_d; oval_q <= oval_d;
      if (cfg_fire) begin
        if (cfg_index_i == 1'(CfgNPlots)) nplots_q <= cfg_data_i[6:0];
        else decay_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_e'(s_axis_tdata[1:0]);
      bad_q  <= bad;
      addr_q <= AW'(tri_v);
      dist_q <= s_axis_tdata[47:16];
      w_q    <= s_axis_tdata[79:48];
    end
    if (mwe) mem[maddr] <= mwdata;
    rdata_q <= mem[addr_q];
  end
endmodule

[rtl/tcpa_checker.sv]
// Port-level checker for the tapered covariance pair accumulator.
// Depends on tcpa_pkg; bound to the top level below.
module tcpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  import tcpa_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != ST_RSV)
    else $error("reserved status");

  a_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[49:2] == '0)
    else $error("value on error status");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");
endmodule

bind tapered_covariance_pair_accumulator tcpa_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[tb/tapered_covariance_pair_accumulator_tb.sv]
// Testbench for tapered_covariance_pair_accumulator: directed and random pair streams
// checked against an in-bench fixed-point covariance predictor. Depends on tcpa_pkg.
module tapered_covariance_pair_accumulator_tb;
  import tcpa_pkg::*;

  localparam int unsigned PLOTS = 64;
  localparam int unsigned DEPTH = PLOTS * (PLOTS + 1) / 2;
  localparam int unsigned STALL_LIMIT = 40000;

  typedef struct packed {
    status_e     status;
    logic [47:0] value;
  } cov_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  tapered_covariance_pair_accumulator #(.MAX_PLOTS(PLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic signed [47:0] cov_model [DEPTH];
  logic [6:0]         plots_cfg = 7'd64;
  logic [31:0]        decay_cfg = 32'd65536;
  logic [63:0]        pow2_q30 [17] = '{
    64'd1073741824, 64'd1028218693, 64'd984625594, 64'd942880699,
    64'd902905651,  64'd864625413,  64'd827968132, 64'd792864999,
    64'd759250125,  64'd727060413,  64'd696235435, 64'd666717336,
    64'd638450709,  64'd611382493,  64'd585461879, 64'd560640218,
    64'd536870912};

  logic [79:0]  pending_items[$];
  cov_result_t  expected_results[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  err_count = 0;
  int unsigned  quiet_cycles = 0;
  logic [6:0]   last_row = 7'd1;
  logic [6:0]   last_col = 7'd1;

  function automatic void add_pending(input logic [79:0] item);
    pending_items = {pending_items, item};
  endfunction

  // exp(-x), x in Q32.32, result Q1.30; table lookup with linear interpolation
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
    logic [127:0] y;
    logic [63:0]  n, hi, lo, e;
    logic [3:0]   i;
    logic [19:0]  t;
    if (x[63:32] >= 64) return 64'd0;
    y = ({64'd0, x >> 8} * 128'd1549082005) >> 30;
    n = y[87:24];
    i = y[23:20];
    t = y[19:0];
    hi = pow2_q30[i];
    lo = pow2_q30[i + 1];
    e = hi - (((hi - lo) * {44'd0, t}) >> 20);
    if (n > 40) return 64'd0;
    return e >> n;
  endfunction

  // lower-triangle address; returns 0 when either index is out of range
  function automatic bit entry_addr(input logic [6:0] row, input logic [6:0] col,
                                    output int unsigned where);
    int unsigned lim, r, c, hi, lo;
    lim = (plots_cfg < PLOTS) ? plots_cfg : PLOTS;
    where = 0;
    if (row < 1 || row > lim || col < 1 || col > lim) return 1'b0;
    r = row - 1;
    c = col - 1;
    hi = (r > c) ? r : c;
    lo = (r > c) ? c : r;
    where = hi * (hi + 1) / 2 + lo;
    return 1'b1;
  endfunction

  task automatic apply_pair_item(input logic [79:0] item);
    cmd_e               cmd;
    logic [31:0]        wraw;
    logic [63:0]        mag, e, contrib;
    logic signed [63:0] sum;
    int unsigned        where;
    cov_result_t        res;
    cmd = cmd_e'(item[1:0]);
    wraw = item[79:48];
    res.status = ST_OK;
    res.value = '0;
    case (cmd)
      CMD_ACC: begin
        if (!entry_addr(item[8:2], item[15:9], where)) begin
          res.status = ST_IDX;
        end else begin
          mag = wraw[31] ? (64'h1_0000_0000 - {32'd0, wraw}) : {32'd0, wraw};
          e = exp_neg_q30({32'd0, decay_cfg} * {32'd0, item[47:16]});
          contrib = (mag * e + 64'd2097152) >> 22;
          if (wraw[31]) contrib = -contrib;
          sum = 64'(cov_model[where]) + $signed(contrib);
          if (sum > 64'sd140737488355327) begin
            sum = 64'sd140737488355327;
            res.status = ST_SAT;
          end else if (sum < -64'sd140737488355328) begin
            sum = -64'sd140737488355328;
            res.status = ST_SAT;
          end
          cov_model[where] = sum[47:0];
        end
      end
      CMD_READ: begin
        if (!entry_addr(item[8:2], item[15:9], where)) res.status = ST_IDX;
        else res.value = cov_model[where];
      end
      CMD_CLEAR: begin
        for (int k = 0; k < DEPTH; k++) cov_model[k] = '0;
      end
      default: ;
    endcase
    expected_results = {expected_results, res};
  endtask

  function automatic logic [79:0] pack_item(input cmd_e cmd, input logic [6:0] row,
                                            input logic [6:0] col,
                                            input logic [31:0] pair_dist,
                                            input logic [31:0] w);
    return {w, pair_dist, col, row, cmd};
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom) >>> $urandom_range(0, 31));
    endcase
  endfunction

  // mostly well-formed accumulate/read traffic, some reuse of the last pair
  // (same-entry hits), a little noise and the odd clear
  task automatic push_random_item();
    int unsigned r, lim;
    logic [6:0]  row, col;
    logic [31:0] pair_dist;
    r = $urandom_range(0, 199);
    lim = (plots_cfg < PLOTS) ? plots_cfg : PLOTS;
    pair_dist = $urandom >> $urandom_range(0, 31);
    if (r == 0) begin
      add_pending(pack_item(CMD_CLEAR, 7'($urandom), 7'($urandom), $urandom, $urandom));
    end else if (r < 12) begin
      add_pending({$urandom, $urandom, 7'($urandom), 7'($urandom), 2'($urandom)});
    end else begin
      if ($urandom_range(0, 9) < 3 || lim == 0) begin
        row = (lim == 0) ? 7'($urandom) : last_row;
        col = (lim == 0) ? 7'($urandom) : last_col;
      end else begin
        row = 7'($urandom_range(1, lim));
        col = 7'($urandom_range(1, lim));
      end
      last_row = row;
      last_col = col;
      add_pending(pack_item(($urandom_range(0, 9) < 7) ? CMD_ACC : CMD_READ,
                            row, col, pair_dist, pick_weight()));
    end
  endtask

  // stimulus driver: the tdata register itself feeds the predictor on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) apply_pair_item(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata  <= pending_items.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    cov_result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d value %h", $time, m_tdata[1:0],
                   m_tdata[49:2]);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[1:0] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_tdata[1:0]);
            err_count++;
          end
          if (m_tdata[49:2] !== want.value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.value,
                     m_tdata[49:2]);
            err_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction (reset sweep and clears included)
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input int unsigned idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CfgNPlots) plots_cfg = data[6:0];
    else decay_cfg = data;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || s_tvalid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] n, input logic [31:0] decay,
                           input int unsigned sp, input int unsigned rp,
                           input int unsigned count);
    write_reg(CfgNPlots, n);
    write_reg(CfgDecay, decay);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    repeat (count) push_random_item();
    drain();
  endtask

  initial begin
    // store is all zero after reset
    foreach (cov_model[k]) cov_model[k] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, mirroring, bad indices, unused command, clear
    add_pending(pack_item(CMD_ACC, 7'd1, 7'd1, 32'd0, 32'h7FFF_FFFF));
    add_pending(pack_item(CMD_READ, 7'd1, 7'd1, 32'd0, 32'd0));
    add_pending(pack_item(CMD_ACC, 7'd64, 7'd1, 32'hFFFF_FFFF, 32'h8000_0000));
    add_pending(pack_item(CMD_ACC, 7'd64, 7'd2, 32'h0001_0000, 32'h8000_0000));
    add_pending(pack_item(CMD_READ, 7'd2, 7'd64, 32'd0, 32'd0));
    add_pending(pack_item(CMD_ACC, 7'd0, 7'd5, 32'd100, 32'h0001_0000));
    add_pending(pack_item(CMD_READ, 7'd3, 7'd65, 32'd0, 32'd0));
    add_pending(pack_item(CMD_READ, 7'd127, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_pending(pack_item(CMD_NOP, 7'd127, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_pending(pack_item(CMD_ACC, 7'd10, 7'd20, 32'h0000_8000, 32'h0001_0000));
    add_pending(pack_item(CMD_ACC, 7'd20, 7'd10, 32'h0000_8000, 32'hFFFF_0000));
    add_pending(pack_item(CMD_READ, 7'd20, 7'd10, 32'd0, 32'd0));
    add_pending(pack_item(CMD_CLEAR, 7'd0, 7'd0, 32'd0, 32'd0));
    add_pending(pack_item(CMD_READ, 7'd1, 7'd1, 32'd0, 32'd0));
    add_pending(pack_item(CMD_READ, 7'd64, 7'd64, 32'd0, 32'd0));
    add_pending(pack_item(CMD_ACC, 7'd64, 7'd64, 32'h0040_0000, 32'h7FFF_FFFF));
    add_pending(pack_item(CMD_READ, 7'd64, 7'd64, 32'd0, 32'd0));
    drain();

    // register extremes, zero plots and zero decay among them;
    // one plot with slow decay piles everything onto a single entry -> saturation
    run_phase(32'd64, 32'd65536, 0, 0, 370);
    run_phase(32'd1, 32'd1, 51, 0, 370);
    run_phase(32'd0, 32'hFFFF_FFFF, 0, 51, 120);
    run_phase(32'd127, 32'd0, 31, 31, 370);
    run_phase(32'd1, 32'd0, 0, 0, 300);
    run_phase(32'd37, 32'h0002_3456, 31, 31, 300);

    repeat (50) @(posedge clk_i);
    if (err_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
